@@ rtl/u64alu_pkg.sv @@
// Shared types, widths and operator codes for the 64-bit binary-operator unit.
package u64alu_pkg;

	localparam int DATA_WIDTH = 64;
	localparam int SHAMT_W = $clog2(DATA_WIDTH);
	localparam int LO_W = DATA_WIDTH / 2;
	localparam int HI_W = DATA_WIDTH - LO_W;

	typedef logic [DATA_WIDTH-1:0] data_t;

	typedef enum logic [3:0] {
		OP_ADD = 4'd0,
		OP_SUB = 4'd1,
		OP_MUL = 4'd2,
		OP_DIV = 4'd3,
		OP_MOD = 4'd4,
		OP_SHL = 4'd5,
		OP_SHR = 4'd6,
		OP_LT  = 4'd7,
		OP_GT  = 4'd8,
		OP_LE  = 4'd9,
		OP_GE  = 4'd10,
		OP_EQ  = 4'd11,
		OP_NE  = 4'd12,
		OP_AND = 4'd13,
		OP_OR  = 4'd14
	} alu_op_t;

	typedef struct packed {
		logic [3:0]  op;
		logic [63:0] left_operand;
		logic [63:0] right_operand;
	} alu_req_t;

	typedef struct packed {
		logic [63:0] result_value;
		logic        divide_by_zero;
	} alu_rsp_t;

	typedef struct packed {
		logic [3:0] op;
		data_t      side;
		logic       dz;
	} div_tag_t;

endpackage

@@ rtl/u64_binary_operator_alu.sv @@
// Top level of the pipelined 64-bit binary-operator unit.
//
// Channel   Ports           Transfer
// request   start, req      rising edge with start high and busy low
// result    done, rsp       rising edge that ends the cycle with done high
//
// A new request can be taken every cycle; busy is never raised.
// Each result is on rsp in request order, after the s1, s2 and s3 operand stages, then
// the one-bit-per-stage divider pipeline that every operation passes through, then the
// s4 output register.
// Reset clears only the valid bits; no pipeline stage ever waits on the receiver.
module u64_binary_operator_alu import u64alu_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  alu_req_t req,
	output logic     done,
	output alu_rsp_t rsp
);

	logic       valid_s1, valid_s2, valid_s3, valid_s4;
	logic [3:0] op_s1, op_s2, op_s3;
	data_t      a_s1, a_s2, a_s3;
	data_t      b_s1, b_s2, b_s3;
	data_t      simple_s2, simple_s3;
	logic       dz_s2, dz_s3;
	data_t      simple;
	logic       dz;
	logic       shift_big;
	data_t      prod_s3;
	div_tag_t   tag_in;
	logic       div_valid;
	data_t      quot;
	data_t      rem;
	div_tag_t   tag_out;
	data_t      final_val;
	alu_rsp_t   rsp_s4;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		op_s1 <= req.op;
		a_s1 <= req.left_operand[DATA_WIDTH-1:0];
		b_s1 <= req.right_operand[DATA_WIDTH-1:0];
	end

	always_comb begin
		shift_big = {1'b0, b_s1} >= (DATA_WIDTH+1)'(DATA_WIDTH);
		dz = 1'b0;
		case (op_s1)
			OP_ADD: simple = a_s1 + b_s1;
			OP_SUB: simple = a_s1 - b_s1;
			OP_SHL: simple = shift_big ? '0 : a_s1 << b_s1[SHAMT_W-1:0];
			OP_SHR: simple = shift_big ? '0 : a_s1 >> b_s1[SHAMT_W-1:0];
			OP_LT:  simple = DATA_WIDTH'(a_s1 < b_s1);
			OP_GT:  simple = DATA_WIDTH'(a_s1 > b_s1);
			OP_LE:  simple = DATA_WIDTH'(a_s1 <= b_s1);
			OP_GE:  simple = DATA_WIDTH'(a_s1 >= b_s1);
			OP_EQ:  simple = DATA_WIDTH'(a_s1 == b_s1);
			OP_NE:  simple = DATA_WIDTH'(a_s1 != b_s1);
			OP_AND: simple = DATA_WIDTH'((a_s1 != '0) && (b_s1 != '0));
			OP_OR:  simple = DATA_WIDTH'((a_s1 != '0) || (b_s1 != '0));
			OP_DIV, OP_MOD: begin
				simple = '0;
				dz = (b_s1 == '0);
			end
			default: simple = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		op_s2 <= op_s1;
		a_s2 <= a_s1;
		b_s2 <= b_s1;
		simple_s2 <= simple;
		dz_s2 <= dz;
		op_s3 <= op_s2;
		a_s3 <= a_s2;
		b_s3 <= b_s2;
		simple_s3 <= simple_s2;
		dz_s3 <= dz_s2;
	end

	u64alu_mul u_mul (
		.clk     (clk),
		.a       (a_s1),
		.b       (b_s1),
		.prod_s3 (prod_s3)
	);

	always_comb begin
		tag_in.op = op_s3;
		tag_in.side = (op_s3 == OP_MUL) ? prod_s3 : simple_s3;
		tag_in.dz = dz_s3;
	end

	u64alu_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s3),
		.num       (a_s3),
		.den       (b_s3),
		.tag_in    (tag_in),
		.out_valid (div_valid),
		.quot      (quot),
		.rem       (rem),
		.tag_out   (tag_out)
	);

	always_comb begin
		case (tag_out.op)
			OP_DIV:  final_val = tag_out.dz ? '0 : quot;
			OP_MOD:  final_val = tag_out.dz ? '0 : rem;
			default: final_val = tag_out.side;
		endcase
	end

	always_ff @(posedge clk) begin
		rsp_s4.result_value <= 64'(final_val);
		rsp_s4.divide_by_zero <= tag_out.dz;
	end

	assign done = valid_s4;
	assign rsp = rsp_s4;

endmodule

@@ rtl/u64alu_mul.sv @@
// Two-stage wrapping multiplier built from three half-width partial products.
module u64alu_mul import u64alu_pkg::*; (
	input  logic  clk,
	input  data_t a,
	input  data_t b,
	output data_t prod_s3
);

	logic [2*LO_W-1:0] p0_s2;
	logic [HI_W-1:0]   p1_s2;
	logic [HI_W-1:0]   p2_s2;
	logic [HI_W-1:0]   m1;
	logic [HI_W-1:0]   m2;

	always_comb begin
		m1 = HI_W'(a[LO_W-1:0]) * b[DATA_WIDTH-1:LO_W];
		m2 = a[DATA_WIDTH-1:LO_W] * HI_W'(b[LO_W-1:0]);
	end

	always_ff @(posedge clk) begin
		p0_s2 <= (2*LO_W)'(a[LO_W-1:0]) * (2*LO_W)'(b[LO_W-1:0]);
		p1_s2 <= m1;
		p2_s2 <= m2;
	end

	always_ff @(posedge clk) begin
		prod_s3 <= DATA_WIDTH'(p0_s2) + {HI_W'(p1_s2 + p2_s2), {LO_W{1'b0}}};
	end

endmodule

@@ rtl/u64alu_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with a tag carried alongside.
module u64alu_div import u64alu_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  data_t    num,
	input  data_t    den,
	input  div_tag_t tag_in,
	output logic     out_valid,
	output data_t    quot,
	output data_t    rem,
	output div_tag_t tag_out
);

	logic     valid_s [1:DATA_WIDTH];
	data_t    quo_s   [1:DATA_WIDTH];
	data_t    rem_s   [1:DATA_WIDTH];
	data_t    den_s   [1:DATA_WIDTH];
	div_tag_t tag_s   [1:DATA_WIDTH];

	for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_stage
		localparam int K = DATA_WIDTH - 1 - i;
		logic                src_valid;
		data_t               src_quo;
		data_t               src_rem;
		data_t               src_den;
		div_tag_t            src_tag;
		logic [DATA_WIDTH:0] trial;
		logic [DATA_WIDTH:0] diff;
		logic                ge;
		data_t               nxt_quo;

		if (i == 0) begin : g_first
			assign src_valid = in_valid;
			assign src_quo = num;
			assign src_rem = '0;
			assign src_den = den;
			assign src_tag = tag_in;
		end else begin : g_rest
			assign src_valid = valid_s[i];
			assign src_quo = quo_s[i];
			assign src_rem = rem_s[i];
			assign src_den = den_s[i];
			assign src_tag = tag_s[i];
		end

		always_comb begin
			trial = {src_rem, src_quo[K]};
			ge = trial >= {1'b0, src_den};
			diff = trial - {1'b0, src_den};
			nxt_quo = src_quo;
			nxt_quo[K] = ge;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i+1] <= 1'b0;
			end else begin
				valid_s[i+1] <= src_valid;
			end
		end

		always_ff @(posedge clk) begin
			quo_s[i+1] <= nxt_quo;
			rem_s[i+1] <= ge ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
			den_s[i+1] <= src_den;
			tag_s[i+1] <= src_tag;
		end
	end

	assign out_valid = valid_s[DATA_WIDTH];
	assign quot = quo_s[DATA_WIDTH];
	assign rem = rem_s[DATA_WIDTH];
	assign tag_out = tag_s[DATA_WIDTH];

endmodule
